### hw/rtl/mbet_pkg.sv
`default_nettype none
package mbet_pkg;

  // Number format and field widths.
  localparam int FX_W       = 32;
  localparam int FRAC_BITS  = 28;
  localparam int COORD_BITS = 12;
  localparam int DIM_W      = 13;
  localparam int CNT_W      = 16;
  localparam int GRAY_W     = 8;

  // The axis span (max - min) has a magnitude below 2^FX_W.
  localparam int QUO_W  = FX_W;
  localparam int STEP_W = QUO_W + 1;
  // Signed pixel times step; the offset sum adds one more bit.
  localparam int MAP_W  = COORD_BITS + 1 + STEP_W;
  // Truncated magnitude of a product of two fixed-point values.
  localparam int PROD_W = 2 * FX_W - FRAC_BITS;
  // Holds sr - si + cr and ci +/- 2*p without loss.
  localparam int SUM_W  = PROD_W + 2;

  localparam int QUEUE_DEPTH = 2;

  localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((CNT_W + GRAY_W + 7) / 8) * 8;

  // Configuration register map.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_MAX_ITERATIONS = 3'd2;
  localparam logic [2:0] REG_REAL_MIN       = 3'd3;
  localparam logic [2:0] REG_REAL_MAX       = 3'd4;
  localparam logic [2:0] REG_IMAG_MIN       = 3'd5;
  localparam logic [2:0] REG_IMAG_MAX       = 3'd6;

  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH    = DIM_W'(640);
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT   = DIM_W'(480);
  localparam logic [CNT_W-1:0] RST_MAX_ITERATIONS = CNT_W'(256);
  localparam logic [FX_W-1:0]  RST_REAL_MIN       = 32'he000_0000;
  localparam logic [FX_W-1:0]  RST_REAL_MAX       = 32'h1000_0000;
  localparam logic [FX_W-1:0]  RST_IMAG_MIN       = 32'hf000_0000;
  localparam logic [FX_W-1:0]  RST_IMAG_MAX       = 32'h1000_0000;

  typedef logic signed [FX_W-1:0] fx_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [CNT_W-1:0] max_iterations;
    fx_t              real_min;
    fx_t              real_max;
    fx_t              imag_min;
    fx_t              imag_max;
  } cfg_t;

  // One mapped point c of the complex plane.
  typedef struct packed {
    fx_t ci;
    fx_t cr;
  } point_t;

  function automatic logic [FX_W-1:0] fx_mag(input logic [FX_W-1:0] v);
    return v[FX_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/mandelbrot_escape_time_pixel_unit.sv
`default_nettype none
// Channel  | Role                 | Signals
// ---------+----------------------+---------------------------------------------
// s_       | pixel in             | s_tvalid, s_tready, s_tdata (pixel_x, pixel_y)
// m_       | result out           | m_tvalid, m_tready, m_tdata (count, gray)
// APB      | configuration        | psel, penable, pwrite, paddr, pwdata, prdata
//
// In the front end a pixel passes a serial divider per axis, then multiply,
// offset and saturate; in the iteration engine it runs a multiply/accumulate
// loop until it escapes, overflows or reaches the iteration limit.
// A two-entry queue lets the front end map the next pixel while the engine works,
// and the output register lets the engine start anew while a result waits.
// Reset is synchronous and clears all control state; configuration registers
// return to 640, 480, 256, -2.0, 1.0, -1.0 and 1.0.
module mandelbrot_escape_time_pixel_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Configuration port.
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mbet_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [mbet_pkg::DATA_W-1:0]        pwdata,
  output logic      [mbet_pkg::DATA_W-1:0]        prdata,
  output logic                                    pready,
  // Pixel input stream.
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // Bits from the lowest up: pixel_x [11:0], pixel_y [23:12].
  input  wire logic [mbet_pkg::IN_TDATA_W-1:0]    s_tdata,
  // Result output stream.
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // Bits from the lowest up: iteration_count [15:0], gray_level [23:16].
  output logic      [mbet_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  mbet_pkg::cfg_t                   cfg;
  logic                             cfg_write;
  logic [2:0]                       reg_index;
  logic [mbet_pkg::COORD_BITS-1:0]  pixel_x;
  logic [mbet_pkg::COORD_BITS-1:0]  pixel_y;
  logic                             push_valid;
  logic                             push_ready;
  mbet_pkg::point_t                 push_data;
  logic                             pop_valid;
  logic                             pop_ready;
  mbet_pkg::point_t                 pop_data;
  logic [mbet_pkg::CNT_W-1:0]       iteration_count;
  logic [mbet_pkg::GRAY_W-1:0]      gray_level;

  // The port never inserts wait states, so a write lands in its access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[mbet_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width    <= mbet_pkg::RST_IMAGE_WIDTH;
      cfg.image_height   <= mbet_pkg::RST_IMAGE_HEIGHT;
      cfg.max_iterations <= mbet_pkg::RST_MAX_ITERATIONS;
      cfg.real_min       <= mbet_pkg::RST_REAL_MIN;
      cfg.real_max       <= mbet_pkg::RST_REAL_MAX;
      cfg.imag_min       <= mbet_pkg::RST_IMAG_MIN;
      cfg.imag_max       <= mbet_pkg::RST_IMAG_MAX;
    end else if (cfg_write) begin
      case (reg_index)
        mbet_pkg::REG_IMAGE_WIDTH:    cfg.image_width    <= pwdata[mbet_pkg::DIM_W-1:0];
        mbet_pkg::REG_IMAGE_HEIGHT:   cfg.image_height   <= pwdata[mbet_pkg::DIM_W-1:0];
        mbet_pkg::REG_MAX_ITERATIONS: cfg.max_iterations <= pwdata[mbet_pkg::CNT_W-1:0];
        mbet_pkg::REG_REAL_MIN:       cfg.real_min       <= pwdata[mbet_pkg::FX_W-1:0];
        mbet_pkg::REG_REAL_MAX:       cfg.real_max       <= pwdata[mbet_pkg::FX_W-1:0];
        mbet_pkg::REG_IMAG_MIN:       cfg.imag_min       <= pwdata[mbet_pkg::FX_W-1:0];
        mbet_pkg::REG_IMAG_MAX:       cfg.imag_max       <= pwdata[mbet_pkg::FX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read-back of the register file; unused addresses read as zero.
  always_comb begin
    case (reg_index)
      mbet_pkg::REG_IMAGE_WIDTH:    prdata = mbet_pkg::DATA_W'(cfg.image_width);
      mbet_pkg::REG_IMAGE_HEIGHT:   prdata = mbet_pkg::DATA_W'(cfg.image_height);
      mbet_pkg::REG_MAX_ITERATIONS: prdata = mbet_pkg::DATA_W'(cfg.max_iterations);
      mbet_pkg::REG_REAL_MIN:       prdata = cfg.real_min;
      mbet_pkg::REG_REAL_MAX:       prdata = cfg.real_max;
      mbet_pkg::REG_IMAG_MIN:       prdata = cfg.imag_min;
      mbet_pkg::REG_IMAG_MAX:       prdata = cfg.imag_max;
      default:                      prdata = '0;
    endcase
  end

  assign pixel_x = s_tdata[mbet_pkg::COORD_BITS-1:0];
  assign pixel_y = s_tdata[2*mbet_pkg::COORD_BITS-1:mbet_pkg::COORD_BITS];

  // Front end: divides out the axis steps and maps the pixel to c.
  mbet_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mbet_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_data  (pop_data)
  );

  // Back end: escape-time iteration with its own output register.
  mbet_iter u_iter (
    .clk            (clk),
    .rst            (rst),
    .max_iterations (cfg.max_iterations),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_count      (iteration_count)
  );

  // The gray level is the count modulo 256, the low byte of the count.
  assign gray_level = iteration_count[mbet_pkg::GRAY_W-1:0];
  assign m_tdata    = mbet_pkg::OUT_TDATA_W'({gray_level, iteration_count});

endmodule
`default_nettype wire

### hw/rtl/mbet_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. A divisor of zero acts as one.
module mbet_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [mbet_pkg::QUO_W-1:0]    dividend,
  input  wire logic [mbet_pkg::DIM_W-1:0]    divisor,
  output logic                               done,
  output logic      [mbet_pkg::QUO_W-1:0]    quotient
);

  localparam int CNT_BITS = $clog2(mbet_pkg::QUO_W);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(mbet_pkg::QUO_W - 1);

  logic                          busy;
  logic [CNT_BITS-1:0]           cnt;
  logic [mbet_pkg::DIM_W-1:0]    rem;
  logic [mbet_pkg::DIM_W-1:0]    dvs;
  logic [mbet_pkg::QUO_W-1:0]    quo;
  logic [mbet_pkg::DIM_W:0]      shifted;
  logic [mbet_pkg::DIM_W:0]      diff;
  logic                          fits;

  assign shifted  = {rem, quo[mbet_pkg::QUO_W-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= (divisor == '0) ? mbet_pkg::DIM_W'(1) : divisor;
    end else if (busy) begin
      rem <= fits ? diff[mbet_pkg::DIM_W-1:0] : shifted[mbet_pkg::DIM_W-1:0];
      quo <= {quo[mbet_pkg::QUO_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/mbet_front.sv
`default_nettype none
// Front end: takes a pixel, forms the axis steps by division, maps the pixel
// to a saturated point c and hands it to the queue.
module mbet_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire mbet_pkg::cfg_t                   cfg,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [mbet_pkg::COORD_BITS-1:0]  pixel_x,
  input  wire logic [mbet_pkg::COORD_BITS-1:0]  pixel_y,
  output logic                                  push_valid,
  input  wire logic                             push_ready,
  output mbet_pkg::point_t                      push_data
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_MUL  = 2'd2;
  localparam logic [1:0] F_ADD  = 2'd3;

  localparam logic signed [mbet_pkg::MAP_W:0] SAT_MAX =
    (mbet_pkg::MAP_W+1)'($signed({1'b0, {(mbet_pkg::FX_W-1){1'b1}}}));
  localparam logic signed [mbet_pkg::MAP_W:0] SAT_MIN =
    (mbet_pkg::MAP_W+1)'($signed({1'b1, {(mbet_pkg::FX_W-1){1'b0}}}));

  logic [1:0]                          state;
  logic                                accept;
  logic [mbet_pkg::COORD_BITS-1:0]     px;
  logic [mbet_pkg::COORD_BITS-1:0]     py;
  logic                                neg_r;
  logic                                neg_i;
  logic signed [mbet_pkg::FX_W:0]      span_r;
  logic signed [mbet_pkg::FX_W:0]      span_i;
  logic [mbet_pkg::QUO_W-1:0]          mag_r;
  logic [mbet_pkg::QUO_W-1:0]          mag_i;
  logic                                done_r;
  logic                                done_i;
  logic [mbet_pkg::QUO_W-1:0]          quo_r;
  logic [mbet_pkg::QUO_W-1:0]          quo_i;
  logic signed [mbet_pkg::STEP_W-1:0]  step_r;
  logic signed [mbet_pkg::STEP_W-1:0]  step_i;
  logic signed [mbet_pkg::MAP_W-1:0]   prod_r;
  logic signed [mbet_pkg::MAP_W-1:0]   prod_i;
  logic signed [mbet_pkg::MAP_W:0]     sum_r;
  logic signed [mbet_pkg::MAP_W:0]     sum_i;

  assign in_ready = (state == F_IDLE);
  assign accept   = in_valid && in_ready;

  // Span of each axis as a sign and a magnitude for the unsigned divider.
  assign span_r = (mbet_pkg::FX_W+1)'(cfg.real_max) - (mbet_pkg::FX_W+1)'(cfg.real_min);
  assign span_i = (mbet_pkg::FX_W+1)'(cfg.imag_max) - (mbet_pkg::FX_W+1)'(cfg.imag_min);
  assign mag_r  = span_r[mbet_pkg::FX_W] ? mbet_pkg::QUO_W'(-span_r)
                                         : mbet_pkg::QUO_W'(span_r);
  assign mag_i  = span_i[mbet_pkg::FX_W] ? mbet_pkg::QUO_W'(-span_i)
                                         : mbet_pkg::QUO_W'(span_i);

  mbet_div u_div_r (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (mag_r),
    .divisor  (cfg.image_width),
    .done     (done_r),
    .quotient (quo_r)
  );

  mbet_div u_div_i (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (mag_i),
    .divisor  (cfg.image_height),
    .done     (done_i),
    .quotient (quo_i)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            state <= F_DIV;
          end
        end
        F_DIV: begin
          if (done_r && done_i) begin
            state <= F_MUL;
          end
        end
        F_MUL: begin
          state <= F_ADD;
        end
        F_ADD: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px    <= pixel_x;
      py    <= pixel_y;
      neg_r <= span_r[mbet_pkg::FX_W];
      neg_i <= span_i[mbet_pkg::FX_W];
    end
    if (state == F_DIV) begin
      step_r <= neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
      step_i <= neg_i ? -$signed({1'b0, quo_i}) : $signed({1'b0, quo_i});
    end
    if (state == F_MUL) begin
      prod_r <= mbet_pkg::MAP_W'($signed({1'b0, px}) * step_r);
      prod_i <= mbet_pkg::MAP_W'($signed({1'b0, py}) * step_i);
    end
  end

  always_comb begin
    sum_r = (mbet_pkg::MAP_W+1)'(prod_r) + (mbet_pkg::MAP_W+1)'(cfg.real_min);
    sum_i = (mbet_pkg::MAP_W+1)'(prod_i) + (mbet_pkg::MAP_W+1)'(cfg.imag_min);
    if (sum_r > SAT_MAX) begin
      push_data.cr = mbet_pkg::fx_t'(SAT_MAX[mbet_pkg::FX_W-1:0]);
    end else if (sum_r < SAT_MIN) begin
      push_data.cr = mbet_pkg::fx_t'(SAT_MIN[mbet_pkg::FX_W-1:0]);
    end else begin
      push_data.cr = mbet_pkg::fx_t'(sum_r[mbet_pkg::FX_W-1:0]);
    end
    if (sum_i > SAT_MAX) begin
      push_data.ci = mbet_pkg::fx_t'(SAT_MAX[mbet_pkg::FX_W-1:0]);
    end else if (sum_i < SAT_MIN) begin
      push_data.ci = mbet_pkg::fx_t'(SAT_MIN[mbet_pkg::FX_W-1:0]);
    end else begin
      push_data.ci = mbet_pkg::fx_t'(sum_i[mbet_pkg::FX_W-1:0]);
    end
  end

  assign push_valid = (state == F_ADD);

endmodule
`default_nettype wire

### hw/rtl/mbet_queue.sv
`default_nettype none
// Short first-in first-out queue of mapped points between front and back.
module mbet_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mbet_pkg::point_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mbet_pkg::point_t       out_data
);

  localparam int PTR_W = (mbet_pkg::QUEUE_DEPTH > 1) ? $clog2(mbet_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(mbet_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(mbet_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(mbet_pkg::QUEUE_DEPTH);

  mbet_pkg::point_t  slots [mbet_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign in_ready  = (count != CNT_FULL);
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue holds more entries than it has slots");

  a_count_push: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a lone push");

endmodule
`default_nettype wire

### hw/rtl/mbet_iter.sv
`default_nettype none
// Back end: runs z = z*z + c for one point at a time and holds the finished
// count in an output register. Each iteration forms the products, then the sums.
module mbet_iter (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [mbet_pkg::CNT_W-1:0]  max_iterations,
  input  wire logic                        pop_valid,
  output logic                             pop_ready,
  input  wire mbet_pkg::point_t            pop_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [mbet_pkg::CNT_W-1:0]       out_count
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam int FX_W  = mbet_pkg::FX_W;
  localparam int PW    = mbet_pkg::PROD_W;
  localparam int SW    = mbet_pkg::SUM_W;
  localparam logic [PW:0] FOUR = (PW+1)'(1) << (mbet_pkg::FRAC_BITS + 2);

  logic [1:0]                  state;
  mbet_pkg::fx_t               cr;
  mbet_pkg::fx_t               ci;
  mbet_pkg::fx_t               zr;
  mbet_pkg::fx_t               zi;
  logic [mbet_pkg::CNT_W-1:0]  n;
  logic [mbet_pkg::CNT_W-1:0]  n_inc;
  logic [mbet_pkg::CNT_W-1:0]  limit;
  logic [PW-1:0]               sr;
  logic [PW-1:0]               si;
  logic [PW-1:0]               pmag;
  logic                        pneg;
  logic [FX_W-1:0]             ar;
  logic [FX_W-1:0]             ai;
  logic [2*FX_W-1:0]           p_rr;
  logic [2*FX_W-1:0]           p_ii;
  logic [2*FX_W-1:0]           p_ri;
  logic [PW:0]                 sum_sq;
  logic                        escape;
  logic signed [SW-1:0]        nr;
  logic signed [SW-1:0]        ni;
  logic signed [SW-1:0]        twice_p;
  logic                        ovf;
  logic                        out_free;

  assign pop_ready = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  // Products on magnitudes, truncated toward zero.
  assign ar   = mbet_pkg::fx_mag(zr);
  assign ai   = mbet_pkg::fx_mag(zi);
  assign p_rr = ar * ar;
  assign p_ii = ai * ai;
  assign p_ri = ar * ai;

  // The sign of zr*zi turns the doubled product into an add or a subtract.
  assign sum_sq  = {1'b0, sr} + {1'b0, si};
  assign escape  = sum_sq >= FOUR;
  assign twice_p = $signed({1'b0, pmag, 1'b0});
  assign nr      = $signed({2'b00, sr}) - $signed({2'b00, si}) + SW'(cr);
  assign ni      = pneg ? (SW'(ci) - twice_p) : (SW'(ci) + twice_p);
  assign ovf     = !((&nr[SW-1:FX_W-1]) || !(|nr[SW-1:FX_W-1]))
                || !((&ni[SW-1:FX_W-1]) || !(|ni[SW-1:FX_W-1]));
  assign n_inc   = n + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop_valid) begin
            state <= (max_iterations == '0) ? S_OUT : S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (escape || ovf || n_inc == limit) begin
            state <= S_OUT;
          end else begin
            state <= S_MUL;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (pop_valid) begin
          cr    <= pop_data.cr;
          ci    <= pop_data.ci;
          zr    <= '0;
          zi    <= '0;
          n     <= '0;
          limit <= max_iterations;
        end
      end
      S_MUL: begin
        sr   <= p_rr[2*FX_W-1:mbet_pkg::FRAC_BITS];
        si   <= p_ii[2*FX_W-1:mbet_pkg::FRAC_BITS];
        pmag <= p_ri[2*FX_W-1:mbet_pkg::FRAC_BITS];
        pneg <= zr[FX_W-1] ^ zi[FX_W-1];
      end
      S_ACC: begin
        if (!escape) begin
          n  <= n_inc;
          zr <= mbet_pkg::fx_t'(nr[FX_W-1:0]);
          zi <= mbet_pkg::fx_t'(ni[FX_W-1:0]);
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_count <= n;
        end
      end
      default: begin
      end
    endcase
  end

  a_below_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (n < limit))
    else $error("iteration started with the count already at the limit");

  a_acc_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> ($past(state) == S_MUL))
    else $error("sum step entered without a product step");

endmodule
`default_nettype wire

### test/mandelbrot_escape_time_pixel_unit_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the escape-time pixel unit.
//
// Pixel coordinates go in on the input stream, one per transaction. At the moment
// a pixel transaction is accepted, the bench works out the iteration count that
// the block must return for it. This uses its own copy of the configuration
// registers and a fixed-point evaluation of z = z*z + c. The expected result is
// queued. A checker on the output stream pops the oldest expectation for every
// result transaction and compares it field by field.
//
// Registers are written over the APB port only when the block is idle, that is
// when no result is outstanding. Each write is read back at once.
//
// Both stream sides idle in short random bursts. One test holds the output off
// for a long stretch, so that the block fills up and stalls its input.
module mandelbrot_escape_time_pixel_unit_test;
  import mbet_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned ITEM_TARGET  = 1250;
  // Random phases that start after this many pixels run without any idling.
  localparam int unsigned QUIET_FROM   = 1050;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE_CYCLES = 4;

  // Q4.28 values used to set up views of the plane.
  localparam fx_t FX_ONE  = 32'sh1000_0000;
  localparam fx_t FX_LOW  = 32'sh8000_0000;
  localparam fx_t FX_HIGH = 32'sh7fff_ffff;

  // The same limits and the escape radius, held at 64 bits for the predictor.
  localparam longint FX_TOP    = 64'sd2147483647;
  localparam longint FX_BOTTOM = -64'sd2147483648;
  localparam longint RADIUS_SQ = longint'(4) << FRAC_BITS;

  typedef struct {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [CNT_W-1:0]      count;
    logic [GRAY_W-1:0]     gray;
  } escape_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [ADDR_W-1:0]      paddr   = '0;
  logic [DATA_W-1:0]      pwdata  = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // Bits from the lowest up: pixel_x [11:0], pixel_y [23:12].
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // Bits from the lowest up: iteration_count [15:0], gray_level [23:16].
  logic [OUT_TDATA_W-1:0] m_tdata;

  // The bench's own copy of the configuration registers.
  cfg_t frame_cfg;

  // Results still to come out, oldest first.
  escape_result_t expected_results[$];
  escape_result_t want_result;
  escape_result_t got_result;

  int unsigned mismatches      = 0;
  int unsigned items_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned bounded_points  = 0;
  int unsigned register_writes = 0;
  int unsigned cycle_count     = 0;

  // Idling controls. The sender's gaps are decided in the initial process
  // itself. The receiver's stalls and the long hold-off are read by the
  // receiver process.
  bit   tx_gaps      = 1'b1;
  logic rx_stalls    = 1'b1;
  logic output_held  = 1'b0;
  int   rx_stall_left = 0;
  event hold_output;

  mandelbrot_escape_time_pixel_unit dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog. A correct run ends far below this limit, even if every pixel
  // stays bounded up to its iteration limit and every gap and stall is at its
  // longest.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver. It is ready unless it is in a random stall burst or in the long
  // hold-off. The hold-off is counted by its own process further down.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall_left <= 0;
    end else if (output_held) begin
      m_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      m_tready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      rx_stall_left <= $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always begin
    @(hold_output);
    output_held <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    output_held <= 1'b0;
  end

  task automatic report_mismatch(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  // Checker. Every result transaction is matched against the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_result.count = m_tdata[CNT_W-1:0];
      got_result.gray  = m_tdata[CNT_W+GRAY_W-1:CNT_W];
      if (expected_results.size() == 0) begin
        report_mismatch("result with no pixel outstanding", -1, got_result.count);
      end else begin
        want_result = expected_results.pop_front();
        if (got_result.count !== want_result.count) begin
          report_mismatch($sformatf("iteration_count of pixel (%0d,%0d)",
                                    want_result.px, want_result.py),
                          want_result.count, got_result.count);
        end
        if (got_result.gray !== want_result.gray) begin
          report_mismatch($sformatf("gray_level of pixel (%0d,%0d)",
                                    want_result.px, want_result.py),
                          want_result.gray, got_result.gray);
        end
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor.
  // ---------------------------------------------------------------------------

  // One axis of the pixel-to-plane mapping. The step is (hi - lo) / size,
  // truncated toward zero. A size of zero acts as one, and the point is
  // saturated to the 32-bit range.
  function automatic longint plane_coord(logic [COORD_BITS-1:0] pix,
                                         logic [DIM_W-1:0] size, fx_t lo, fx_t hi);
    longint divisor, step, pos, pix_l, lo_l;
    lo_l    = longint'(lo);
    divisor = (size == 0) ? 1 : size;
    pix_l   = pix;
    step    = (longint'(hi) - lo_l) / divisor;
    pos     = pix_l * step + lo_l;
    if (pos > FX_TOP) return FX_TOP;
    if (pos < FX_BOTTOM) return FX_BOTTOM;
    return pos;
  endfunction

  // Fixed-point product, with the magnitude truncated before the sign is
  // restored. This rounds toward zero rather than toward minus infinity.
  function automatic longint fx_product(longint a, longint b);
    longint unsigned ma, mb, p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p  = (ma * mb) >> FRAC_BITS;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [CNT_W-1:0] escape_count(logic [COORD_BITS-1:0] px,
                                                    logic [COORD_BITS-1:0] py);
    longint cr, ci, zr, zi, sr, si, nr, ni;
    int unsigned n;
    cr = plane_coord(px, frame_cfg.image_width, frame_cfg.real_min, frame_cfg.real_max);
    ci = plane_coord(py, frame_cfg.image_height, frame_cfg.imag_min, frame_cfg.imag_max);
    zr = 0;
    zi = 0;
    n  = 0;
    while (n < frame_cfg.max_iterations) begin
      sr = fx_product(zr, zr);
      si = fx_product(zi, zi);
      if (sr + si >= RADIUS_SQ) break;
      nr = sr - si + cr;
      ni = 2 * fx_product(zr, zi) + ci;
      n++;
      // A component that leaves the number range counts as an escape. The
      // iteration in which it happens is still counted.
      if (nr > FX_TOP || nr < FX_BOTTOM || ni > FX_TOP || ni < FX_BOTTOM) break;
      zr = nr;
      zi = ni;
    end
    return n[CNT_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] register_value(logic [2:0] idx);
    case (idx)
      REG_IMAGE_WIDTH:    return DATA_W'(frame_cfg.image_width);
      REG_IMAGE_HEIGHT:   return DATA_W'(frame_cfg.image_height);
      REG_MAX_ITERATIONS: return DATA_W'(frame_cfg.max_iterations);
      REG_REAL_MIN:       return frame_cfg.real_min;
      REG_REAL_MAX:       return frame_cfg.real_max;
      REG_IMAG_MIN:       return frame_cfg.imag_min;
      REG_IMAG_MAX:       return frame_cfg.imag_max;
      default:            return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Bus tasks.
  // ---------------------------------------------------------------------------

  // A read takes a setup and an access cycle. prdata is sampled on the falling
  // edge inside the access cycle, so that no update at the clock edge can
  // race with the sampling. Each read then leaves the bus idle.
  task automatic read_register(logic [2:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== register_value(idx)) begin
      report_mismatch($sformatf("readback of register %0d", idx),
                      register_value(idx), prdata);
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // The block takes the write at the edge that ends the access cycle. The
  // bench's copy is updated at that same edge, and the register is then read
  // back.
  task automatic write_register(logic [2:0] idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:    frame_cfg.image_width    = value[DIM_W-1:0];
      REG_IMAGE_HEIGHT:   frame_cfg.image_height   = value[DIM_W-1:0];
      REG_MAX_ITERATIONS: frame_cfg.max_iterations = value[CNT_W-1:0];
      REG_REAL_MIN:       frame_cfg.real_min       = value;
      REG_REAL_MAX:       frame_cfg.real_max       = value;
      REG_IMAG_MIN:       frame_cfg.imag_min       = value;
      REG_IMAG_MAX:       frame_cfg.imag_max       = value;
      default: ;
    endcase
    register_writes++;
    read_register(idx);
  endtask

  task automatic set_view(fx_t rmin, fx_t rmax, fx_t imin, fx_t imax);
    write_register(REG_REAL_MIN, rmin);
    write_register(REG_REAL_MAX, rmax);
    write_register(REG_IMAG_MIN, imin);
    write_register(REG_IMAG_MAX, imax);
  endtask

  // ---------------------------------------------------------------------------
  // Stream tasks.
  // ---------------------------------------------------------------------------

  // Offers one pixel and waits until it is accepted. The expectation is worked
  // out at that moment. tvalid is left high, so that a pixel offered straight
  // after runs back to back. It is lowered only for a gap, or when the bench
  // waits for the block to drain.
  task automatic send_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
    escape_result_t want;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({py, px});
    do @(posedge clk); while (!s_tready);
    want.px    = px;
    want.py    = py;
    want.count = escape_count(px, py);
    want.gray  = want.count[GRAY_W-1:0];
    expected_results.push_back(want);
    items_sent++;
    if (want.count == frame_cfg.max_iterations) bounded_points++;
  endtask

  // Every pixel gives exactly one result. The block is therefore idle once
  // the last expected result has gone out. A settling wait follows before the
  // bus is touched again.
  task automatic drain_block();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  task automatic test_reset_values();
    read_register(REG_IMAGE_WIDTH);
    read_register(REG_IMAGE_HEIGHT);
    read_register(REG_MAX_ITERATIONS);
    read_register(REG_REAL_MIN);
    read_register(REG_REAL_MAX);
    read_register(REG_IMAG_MIN);
    read_register(REG_IMAG_MAX);
  endtask

  // The view after reset. It covers the corners of the pixel range, a point
  // inside the set that runs to the full limit, and alternating bit patterns.
  // The far corner lies well outside a 640 x 480 image, so the mapping is
  // extrapolated there.
  task automatic test_default_view();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'd320, 12'd240);
    send_pixel(12'haaa, 12'h555);
    send_pixel(12'h555, 12'haaa);
    drain_block();
  endtask

  task automatic test_iteration_limits();
    // A zero limit must give a count of zero, wherever the point lies.
    write_register(REG_MAX_ITERATIONS, 0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd320, 12'd240);
    drain_block();
    write_register(REG_MAX_ITERATIONS, 1);
    send_pixel(12'd320, 12'd240);
    drain_block();
    // With a collapsed view every pixel maps to the origin, which never
    // escapes. This single pixel runs the full 16-bit limit, and its gray
    // level wraps to 255.
    set_view(0, 0, 0, 0);
    write_register(REG_MAX_ITERATIONS, 16'hffff);
    send_pixel(12'hfff, 12'd0);
    drain_block();
  endtask

  // A one-pixel image spanning the whole number range. It drives the mapped
  // point into saturation at both ends, in the forward and in the reversed
  // direction. With four integer bits, z stays inside |z| < 2 before every
  // step, and c can only be large on the first step. A component therefore
  // cannot leave the range in the middle of an iteration. These corners,
  // which escape after one step, are as close as that case gets.
  task automatic test_saturated_points();
    write_register(REG_IMAGE_WIDTH, 1);
    write_register(REG_IMAGE_HEIGHT, 1);
    write_register(REG_MAX_ITERATIONS, 16);
    set_view(FX_LOW, FX_HIGH, FX_LOW, FX_HIGH);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    drain_block();
    set_view(FX_HIGH, FX_LOW, FX_HIGH, FX_LOW);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'd1, 12'd1);
    drain_block();
  endtask

  // A width or height of zero must behave as a size of one.
  task automatic test_zero_size();
    write_register(REG_IMAGE_WIDTH, 0);
    write_register(REG_IMAGE_HEIGHT, 0);
    write_register(REG_MAX_ITERATIONS, 32);
    set_view(-2 * FX_ONE, FX_ONE, -FX_ONE, FX_ONE);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd2, 12'd0);
    send_pixel(12'haaa, 12'h555);
    drain_block();
  endtask

  // Both axes reversed, so that the steps are negative. The sizes are the
  // largest image and the largest value that the field can hold.
  task automatic test_reversed_axes();
    write_register(REG_IMAGE_WIDTH, 4096);
    write_register(REG_IMAGE_HEIGHT, 13'h1fff);
    write_register(REG_MAX_ITERATIONS, 64);
    set_view(FX_ONE, -2 * FX_ONE, FX_ONE, -FX_ONE);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd2048, 12'hfff);
    send_pixel(12'd1365, 12'd2730);
    drain_block();
  endtask

  // The output is held off while pixels keep coming in, with no gaps between
  // them. The front end, the queue, the engine and the output register all
  // fill up, so the input must stall until the hold-off ends.
  task automatic test_back_pressure();
    int i;
    write_register(REG_IMAGE_WIDTH, 640);
    write_register(REG_IMAGE_HEIGHT, 480);
    write_register(REG_MAX_ITERATIONS, 8);
    set_view(-2 * FX_ONE, FX_ONE, -FX_ONE, FX_ONE);
    tx_gaps = 1'b0;
    -> hold_output;
    for (i = 0; i < 10; i++) begin
      send_pixel($urandom_range(0, 639), $urandom_range(0, 479));
    end
    drain_block();
    tx_gaps = 1'b1;
  endtask

  // Image sizes are mostly in range, with the field's extremes now and then.
  function automatic logic [DIM_W-1:0] pick_size();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return DIM_W'(4096);
      default: return DIM_W'($urandom_range(1, 4096));
    endcase
  endfunction

  // Most coordinates fall inside the image. The rest are spread over the
  // whole field.
  function automatic logic [COORD_BITS-1:0] pick_coord(logic [DIM_W-1:0] size);
    if (size != 0 && $urandom_range(0, 3) != 0) begin
      return $urandom_range(0, (size > 4096) ? 4095 : size - 1);
    end
    return $urandom_range(0, 4095);
  endfunction

  // Random views of the plane. Each phase writes a fresh setting, then sends a
  // batch of pixels. Most views are windows around the set, some of them
  // reversed. A quarter use arbitrary 32-bit edges, so that every register bit
  // toggles. Iteration limits stay small, to keep the run short, and every
  // eighth phase uses a few hundred.
  task automatic test_random_views();
    int phase_no, batch, i;
    bit idle;
    fx_t centre_r, centre_i, half_r, half_i;
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      idle = (items_sent < QUIET_FROM) && (phase_no % 3 != 2);
      tx_gaps   = idle;
      rx_stalls <= idle;
      write_register(REG_IMAGE_WIDTH, pick_size());
      write_register(REG_IMAGE_HEIGHT, pick_size());
      if (phase_no % 8 == 7) write_register(REG_MAX_ITERATIONS, $urandom_range(100, 400));
      else write_register(REG_MAX_ITERATIONS, $urandom_range(0, 48));
      if ($urandom_range(0, 3) == 0) begin
        set_view($urandom(), $urandom(), $urandom(), $urandom());
      end else begin
        centre_r = fx_t'($urandom_range(0, 32'h3000_0000)) - 32'sh2800_0000;
        centre_i = fx_t'($urandom_range(0, 32'h3000_0000)) - 32'sh1800_0000;
        half_r   = fx_t'($urandom_range(32'h0001_0000, 32'h1000_0000));
        half_i   = fx_t'($urandom_range(32'h0001_0000, 32'h1000_0000));
        if ($urandom_range(0, 5) == 0) begin
          set_view(centre_r + half_r, centre_r - half_r, centre_i + half_i, centre_i - half_i);
        end else begin
          set_view(centre_r - half_r, centre_r + half_r, centre_i - half_i, centre_i + half_i);
        end
      end
      batch = $urandom_range(20, 60);
      for (i = 0; i < batch && items_sent < ITEM_TARGET; i++) begin
        send_pixel(pick_coord(frame_cfg.image_width), pick_coord(frame_cfg.image_height));
      end
      drain_block();
      phase_no++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------

  initial begin
    frame_cfg.image_width    = 640;
    frame_cfg.image_height   = 480;
    frame_cfg.max_iterations = 256;
    frame_cfg.real_min       = -2 * FX_ONE;
    frame_cfg.real_max       = FX_ONE;
    frame_cfg.imag_min       = -FX_ONE;
    frame_cfg.imag_max       = FX_ONE;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_default_view();
    test_iteration_limits();
    test_saturated_points();
    test_zero_size();
    test_reversed_axes();
    test_back_pressure();
    test_random_views();

    drain_block();
    repeat (50) @(posedge clk);

    $display("Checked %0d results for %0d pixels: %0d ran to the iteration limit, %0d escaped.",
             results_checked, items_sent, bounded_points, items_sent - bounded_points);
    $display("Made %0d register writes, each read back, and held the output off for %0d cycles.",
             register_writes, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
